### rtl/csv_pkg.sv
`default_nettype none
package csv_pkg;

    localparam int unsigned MAX_ROWS   = 65536;
    localparam int unsigned ROW_W      = 17;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned SQSUM_W    = 47;
    localparam int unsigned VAR_W      = 40;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned DEN_W      = 32;
    localparam int unsigned PROD_W     = 64;
    localparam int unsigned DVD_W      = PROD_W + FRAC_W;
    localparam int unsigned STEP_W     = $clog2(DVD_W);
    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned Q_AW       = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [ROW_W-1:0]   count;
        logic [SUM_W-1:0]   sum;
        logic [SQSUM_W-1:0] sqsum;
    } t_col_rec;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_SQR,
        BK_SUB,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

### rtl/csv_front.sv
`default_nettype none
module csv_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [csv_pkg::ROW_W-1:0]       i_cfg_wdata,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [csv_pkg::SAMPLE_W-1:0]    s_axis_tdata,
    input  wire                            i_q_full,
    output logic                           o_push,
    output csv_pkg::t_col_rec              o_rec
);
    import csv_pkg::*;

    logic [ROW_W-1:0]   r_row_count;
    logic [ROW_W-1:0]   r_rows_seen;
    logic [SUM_W-1:0]   r_sum;
    logic [SQSUM_W-1:0] r_sqsum;

    logic [ROW_W-1:0]        n_eff;
    logic [ROW_W-1:0]        n_count;
    logic [SUM_W-1:0]        n_sum;
    logic [SQSUM_W-1:0]      n_sqsum;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic                    accept;
    logic                    col_end;

    always_comb begin
        if (r_row_count == '0) begin
            n_eff = ROW_W'(1);
        end else if (r_row_count > ROW_W'(MAX_ROWS)) begin
            n_eff = ROW_W'(MAX_ROWS);
        end else begin
            n_eff = r_row_count;
        end
    end

    assign s_axis_tready = !i_q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sq            = $signed(s_axis_tdata) * $signed(s_axis_tdata);
    assign n_count       = r_rows_seen + ROW_W'(1);
    assign n_sum         = r_sum + {{(SUM_W-SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata};
    assign n_sqsum       = r_sqsum + SQSUM_W'($unsigned(sq));
    assign col_end       = n_count >= n_eff;

    assign o_push        = accept && col_end;
    assign o_rec.count   = n_count;
    assign o_rec.sum     = n_sum;
    assign o_rec.sqsum   = n_sqsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_W'(1);
        end else if (i_cfg_we) begin
            r_row_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_seen <= '0;
            r_sum       <= '0;
            r_sqsum     <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_rows_seen <= '0;
                r_sum       <= '0;
                r_sqsum     <= '0;
            end else begin
                r_rows_seen <= n_count;
                r_sum       <= n_sum;
                r_sqsum     <= n_sqsum;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/csv_queue.sv
`default_nettype none
module csv_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  csv_pkg::t_col_rec  i_rec,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_empty,
    output csv_pkg::t_col_rec  o_rec
);
    import csv_pkg::*;

    t_col_rec          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_fill;

    assign o_full  = r_fill == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            unique case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_fill <= r_fill + (Q_AW+1)'(1);
                2'b01:   r_fill <= r_fill - (Q_AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/csv_back.sv
`default_nettype none
module csv_back (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_q_empty,
    input  csv_pkg::t_col_rec                    i_rec,
    output logic                                 o_pop,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [csv_pkg::SUM_W+csv_pkg::VAR_W-1:0] m_axis_tdata,
    output logic [0:0]                           m_axis_tuser
);
    import csv_pkg::*;

    t_back_state          r_state;
    t_back_state          n_state;
    t_col_rec             r_rec;
    logic [SUM_W-1:0]     r_abs;
    logic [ROW_W+SUM_W-1:0] r_prod;
    logic [DEN_W-1:0]     r_den;
    logic [PROD_W-1:0]    r_a;
    logic [PROD_W-1:0]    r_b;
    logic [DVD_W-1:0]     r_dvd;
    logic [DEN_W-1:0]     r_rem;
    logic [VAR_W-1:0]     r_quo;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid;
    logic [SUM_W-1:0]     r_out_sum;
    logic [VAR_W-1:0]     r_out_var;
    logic                 r_out_ok;

    logic                 load_out;
    logic                 multi_row;
    logic [DEN_W:0]       rem_sh;
    logic                 rem_ge;
    logic [SQSUM_W-SUM_W-1:0] sq_hi;
    logic [2*ROW_W-1:0]   den_full;

    assign multi_row = r_rec.count >= ROW_W'(2);
    assign rem_sh    = {r_rem, r_dvd[DVD_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, r_den};
    assign sq_hi     = r_rec.sqsum[SQSUM_W-1:SUM_W];
    assign den_full  = (2*ROW_W)'(r_rec.count) * (2*ROW_W)'(r_rec.count - ROW_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (!i_q_empty) n_state = BK_MUL_LO;
            BK_MUL_LO: n_state = multi_row ? BK_MUL_HI : BK_DONE;
            BK_MUL_HI: n_state = BK_SQR;
            BK_SQR:    n_state = BK_SUB;
            BK_SUB:    n_state = BK_DIV;
            BK_DIV:    if (r_step == '0) n_state = BK_DONE;
            BK_DONE:   if (!r_out_valid || m_axis_tready) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == BK_IDLE) && !i_q_empty;
        load_out = (r_state == BK_DONE) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_rec <= i_rec;
                r_abs <= i_rec.sum[SUM_W-1] ? (SUM_W'(0) - i_rec.sum) : i_rec.sum;
                r_quo <= '0;
            end
            BK_MUL_LO: begin
                r_prod <= (ROW_W+SUM_W)'(r_rec.count) * (ROW_W+SUM_W)'(r_rec.sqsum[SUM_W-1:0]);
                r_den  <= den_full[DEN_W-1:0];
            end
            BK_MUL_HI: begin
                r_a <= PROD_W'(r_prod)
                     + {SUM_W'(r_rec.count) * SUM_W'(sq_hi), SUM_W'(0)};
            end
            BK_SQR: begin
                r_b <= PROD_W'(r_abs) * PROD_W'(r_abs);
            end
            BK_SUB: begin
                r_dvd  <= {((r_a >= r_b) ? (r_a - r_b) : PROD_W'(0)), FRAC_W'(0)};
                r_rem  <= '0;
                r_step <= STEP_W'(DVD_W - 1);
            end
            BK_DIV: begin
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                r_rem  <= rem_ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
                r_quo  <= {r_quo[VAR_W-2:0], rem_ge};
                r_step <= r_step - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_sum <= r_rec.sum;
            r_out_var <= multi_row ? r_quo : VAR_W'(0);
            r_out_ok  <= multi_row;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_var, r_out_sum};
    assign m_axis_tuser[0] = r_out_ok;

endmodule
`default_nettype wire

### rtl/column_sum_and_variance.sv
// Column sum and unbiased sample variance over a stream of signed 16-bit samples.
// Input stream (s_axis): one sample per transaction, column by column.
// Output stream (m_axis): one transaction per column, after its last row:
//   tdata = {variance (40 bits, 8 fraction bits, truncated), column sum (32 bits)},
//   tuser = variance valid (0 when the column had a single row).
// Config: i_cfg_we/i_cfg_wdata set the rows per column (0 acts as 1, values
// above 65536 act as 65536); write only while the block is idle.
// Throughput: samples are accumulated at one per cycle while s_axis_tready is
// high. Each column end is handed to a two-entry queue; for a column with two or
// more rows the back end runs three multiply steps, one subtract, 72 steps of a
// bit-serial restoring divider and one output load; a single-row column goes
// straight from the first multiply step to the output load.
// When the queue is full, s_axis_tready drops until the back end takes an entry.
// If the receiver stalls, the result is held in the output register; the back
// end waits with the next result and the queue fills, then input stalls.
// Reset (synchronous, active low) clears the counters, accumulators, queue and
// output valid, and sets the rows per column to 1.
`default_nettype none
module column_sum_and_variance (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [16:0]         i_cfg_wdata,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [15:0]         s_axis_tdata,   // [15:0] sample
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [71:0]         m_axis_tdata,   // [31:0] column_sum, [71:32] column_variance
    output logic [0:0]          m_axis_tuser    // [0] variance_valid
);
    import csv_pkg::*;

    t_col_rec push_rec;
    t_col_rec pop_rec;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    csv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    csv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_rec   (pop_rec)
    );

    csv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_rec         (pop_rec),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

### tb/column_stats_checker.sv
`timescale 1ns / 1ps
module column_stats_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [csv_pkg::ROW_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [15:0]                 s_data,     // [15:0] sample
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [71:0]                 m_data,     // [31:0] column_sum, [71:32] column_variance
    input  logic [0:0]                  m_user,     // [0] variance_valid
    output int                          errors,
    output int                          pending,
    output int                          columns_checked,
    output int                          variances_checked
);
    import csv_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [VAR_W-1:0] variance;
        logic             var_ok;
    } t_col_stats;

    t_col_stats expected_columns[$];

    logic [ROW_W-1:0]   rows_reg;
    logic [ROW_W-1:0]   rows_seen;
    logic [SUM_W-1:0]   col_total;
    logic [SQSUM_W-1:0] col_sq_total;
    int                 fail_count;
    int                 col_count;
    int                 var_count;

    // floor((n*sumsq - sum^2) * 256 / (n*(n-1))), n >= 2
    function automatic logic [VAR_W-1:0] fixed_variance(input logic [ROW_W-1:0] n,
                                                        input logic [SUM_W-1:0] sum,
                                                        input logic [SQSUM_W-1:0] sq);
        logic signed [63:0] sum64;
        logic [63:0]        mag, a, b, d, den, q, r;
        sum64 = {{32{sum[SUM_W-1]}}, sum};
        mag   = (sum64 < 0) ? 64'(-sum64) : 64'(sum64);
        a     = 64'(n) * 64'(sq);
        b     = mag * mag;
        d     = (a >= b) ? a - b : 64'd0;
        den   = 64'(n) * (64'(n) - 64'd1);
        q     = d / den;
        r     = d % den;
        return VAR_W'((q << FRAC_W) + ((r << FRAC_W) / den));
    endfunction

    task automatic accumulate(input logic [15:0] raw);
        logic signed [31:0] sx;
        logic [31:0]        sq;
        logic [ROW_W-1:0]   cnt;
        logic [ROW_W-1:0]   n;
        t_col_stats         exp_col;
        sx           = {{16{raw[15]}}, raw};
        sq           = sx * sx;
        col_total    = col_total + sx;
        col_sq_total = col_sq_total + SQSUM_W'(sq);
        cnt          = rows_seen + 1'b1;
        if (rows_reg == '0) begin
            n = ROW_W'(1);
        end else if (rows_reg > MAX_ROWS) begin
            n = ROW_W'(MAX_ROWS);
        end else begin
            n = rows_reg;
        end
        if (cnt < n) begin
            rows_seen = cnt;
        end else begin
            exp_col.sum = col_total;
            if (cnt >= 2) begin
                exp_col.variance = fixed_variance(cnt, col_total, col_sq_total);
                exp_col.var_ok   = 1'b1;
            end else begin
                exp_col.variance = '0;
                exp_col.var_ok   = 1'b0;
            end
            expected_columns.push_back(exp_col);
            rows_seen    = '0;
            col_total    = '0;
            col_sq_total = '0;
        end
    endtask

    task automatic check_column();
        t_col_stats exp_col;
        logic [SUM_W-1:0] got_sum;
        logic [VAR_W-1:0] got_var;
        got_sum = m_data[31:0];
        got_var = m_data[71:32];
        if (expected_columns.size() == 0) begin
            $display("%0t: unexpected result, expected none, got sum=%0d variance=%h valid=%b",
                     $time, $signed(got_sum), got_var, m_user[0]);
            fail_count++;
        end else begin
            exp_col = expected_columns.pop_front();
            col_count++;
            if (exp_col.var_ok)
                var_count++;
            if (got_sum !== exp_col.sum) begin
                $display("%0t: column sum mismatch, expected %0d, got %0d",
                         $time, $signed(exp_col.sum), $signed(got_sum));
                fail_count++;
            end
            if (got_var !== exp_col.variance) begin
                $display("%0t: column variance mismatch, expected %h, got %h",
                         $time, exp_col.variance, got_var);
                fail_count++;
            end
            if (m_user[0] !== exp_col.var_ok) begin
                $display("%0t: variance valid mismatch, expected %b, got %b",
                         $time, exp_col.var_ok, m_user[0]);
                fail_count++;
            end
        end
    endtask

    initial begin
        fail_count = 0;
        col_count  = 0;
        var_count  = 0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rows_reg     = ROW_W'(1);
            rows_seen    = '0;
            col_total    = '0;
            col_sq_total = '0;
            expected_columns.delete();
        end else begin
            // a sample taken at the write edge still sees the old row count
            if (s_valid && s_ready)
                accumulate(s_data);
            if (cfg_we)
                rows_reg = cfg_wdata;
            if (m_valid && m_ready)
                check_column();
        end
        errors            <= fail_count;
        pending           <= expected_columns.size();
        columns_checked   <= col_count;
        variances_checked <= var_count;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import csv_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    // allows for the bit-serial back end and long receiver stalls
    localparam int QUIET_LIMIT  = 20000;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [ROW_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata  = '0;    // [15:0] sample
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [71:0]      m_axis_tdata;          // [31:0] column_sum, [71:32] column_variance
    logic [0:0]       m_axis_tuser;          // [0] variance_valid

    int errors;
    int pending;
    int columns_checked;
    int variances_checked;
    int samples_sent = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    int idle_mix[4]  = '{0, 60, 0, 11};
    int stall_mix[4] = '{0, 0, 60, 11};

    column_sum_and_variance DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    column_stats_checker u_checker (
        .clk               (i_clk),
        .rst_n             (i_rst_n),
        .cfg_we            (i_cfg_we),
        .cfg_wdata         (i_cfg_wdata),
        .s_valid           (s_axis_tvalid),
        .s_ready           (s_axis_tready),
        .s_data            (s_axis_tdata),
        .m_valid           (m_axis_tvalid),
        .m_ready           (m_axis_tready),
        .m_data            (m_axis_tdata),
        .m_user            (m_axis_tuser),
        .errors            (errors),
        .pending           (pending),
        .columns_checked   (columns_checked),
        .variances_checked (variances_checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic [15:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic drain_columns();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_row_count(input logic [ROW_W-1:0] rows);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rows;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($signed(5'($urandom_range(8))) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] random_rows();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ROW_W'(1);
            2:       return ROW_W'(2);
            8:       return ROW_W'($urandom_range(40, 9));
            default: return ROW_W'($urandom_range(8, 3));
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-row columns at the reset row count
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        drain_columns();
        // zero rows acts as one
        set_row_count('0);
        push_sample(16'h0000);
        push_sample(16'h0001);
        drain_columns();
        set_row_count(ROW_W'(2));
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h7FFF);
        drain_columns();
        set_row_count(ROW_W'(3));
        push_sample(16'd1);
        push_sample(16'd2);
        push_sample(16'd3);
        drain_columns();
        // shrink mid-column: column closes at once with four rows
        set_row_count(ROW_W'(5));
        push_sample(16'd7);
        push_sample(16'(-9));
        push_sample(16'd100);
        drain_columns();
        set_row_count(ROW_W'(2));
        push_sample(16'd4);
        drain_columns();
        // grow mid-column
        push_sample(16'd1);
        drain_columns();
        set_row_count(ROW_W'(4));
        push_sample(16'(-2));
        push_sample(16'd30000);
        push_sample(16'(-30000));
        drain_columns();
        // row count above the maximum, then shrunk to close the column
        set_row_count('1);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        drain_columns();
        set_row_count(ROW_W'(2));
        push_sample(16'h1234);
        drain_columns();

        for (int m = 0; m < 4; m++) begin
            sender_idle_pct = idle_mix[m];
            stall_pct       <= stall_mix[m];
            for (int k = 0; k < 4; k++) begin
                drain_columns();
                set_row_count(random_rows());
                repeat (27) push_sample(random_sample());
            end
        end
        drain_columns();

        $display("Covered %0d samples giving %0d column results, %0d with a variance,",
                 samples_sent, columns_checked, variances_checked);
        $display("rows per column 0 to 40, above the maximum and changed mid-column, four flow mixes.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
